[src/vdic_pkg.sv]
// Shared constants, action codes and the converter lookup for the valve sequencer.
package vdic_pkg;

    localparam int unsigned LEVEL_W    = 3;
    localparam int unsigned COUNT_W    = 10;
    localparam int unsigned INTERVAL_W = 8;
    localparam int unsigned DAC_W      = 12;
    localparam int unsigned S_DATA_W   = 8;
    localparam int unsigned S_USER_W   = 2;
    localparam int unsigned M_DATA_W   = 24;

    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_SCAN   = 2'd1;
    localparam logic [1:0] ACT_REMOTE = 2'd2;

    localparam logic [LEVEL_W-1:0]    MODE_AUTO = 3'd6;
    localparam logic [LEVEL_W-1:0]    LEVEL_MAX = 3'd5;
    localparam logic [LEVEL_W-1:0]    PULSE_POS = 3'd3;
    localparam logic [COUNT_W-1:0]    COUNT_MAX = 10'd1023;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd4;

    typedef struct packed {
        logic                 manual_active;
        logic [LEVEL_W-1:0]   level_selected;
        logic [LEVEL_W-1:0]   valve_position;
        logic                 valve_open;
        logic [DAC_W-1:0]     dac_code;
    } result_t;

    function automatic logic [DAC_W-1:0] dac_of(input logic [LEVEL_W-1:0] pos);
        logic [DAC_W-1:0] code;
        case (pos)
            3'd0:    code = 12'd0;
            3'd1:    code = 12'd819;
            3'd2:    code = 12'd1638;
            3'd3:    code = 12'd2457;
            3'd4:    code = 12'd3276;
            3'd5:    code = 12'd4095;
            3'd6:    code = 12'd818;
            default: code = 12'd1637;
        endcase
        return code;
    endfunction

endpackage

[src/valve_duty_interval_controller_core.sv]
// Valve position sequencer: mode, setpoint and timed pulse stepping with DAC code output.
//
//  channel | dir | handshake            | payload
//  s_      | in  | s_tvalid / s_tready  | tuser: action; tdata: buttons, remote level
//  m_      | out | m_tvalid / m_tready  | tdata: dac code, open, position, level, manual
//  cfg_    | in  | cfg_valid / cfg_ready| cfg_data: on interval in minutes
//
//  One item per cycle unless the result stalls; its result appears in the cycle after
//  the transfer, set by the single update stage between state and output registers.
//  Reset (aresetn low, synchronous) restores auto mode, level 5, open phase, counter 0.
//  A stalled result holds in the output register; input is taken while the output is
//  empty or the result is taken in the same cycle.
module valve_duty_interval_controller_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [0] btn_auto, [1] btn_up, [2] btn_down, [5:3] remote_level, [7:6] zero
    input  logic [vdic_pkg::S_DATA_W-1:0]      s_tdata,
    // [1:0] action
    input  logic [vdic_pkg::S_USER_W-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [11:0] dac_code, [12] valve_open, [15:13] valve_position,
    // [18:16] level_selected, [19] manual_active, [23:20] zero
    output logic [vdic_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [vdic_pkg::INTERVAL_W-1:0]    cfg_data
);

    logic [vdic_pkg::INTERVAL_W-1:0] on_interval_reg;
    logic [vdic_pkg::LEVEL_W-1:0]    manual_mode_reg, manual_mode_next;
    logic [vdic_pkg::LEVEL_W-1:0]    auto_level_reg, auto_level_next;
    logic [vdic_pkg::LEVEL_W-1:0]    selected_level_reg, selected_level_next;
    logic [vdic_pkg::COUNT_W-1:0]    phase_minutes_reg, phase_minutes_next;
    logic                            open_phase_reg, open_phase_next;
    logic [vdic_pkg::LEVEL_W-1:0]    drive_position_reg, drive_position_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    vdic_pkg::result_t               result_reg, result_next;
    logic                            s_xfer;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{(vdic_pkg::M_DATA_W - $bits(vdic_pkg::result_t)){1'b0}}, result_reg};

    always_comb begin
        logic                         b_auto, b_up, b_down;
        logic [vdic_pkg::LEVEL_W-1:0] remote, lvl, mode;
        logic [vdic_pkg::COUNT_W-1:0] on_ext, off_ext;
        b_auto  = s_tdata[0];
        b_up    = s_tdata[1];
        b_down  = s_tdata[2];
        remote  = s_tdata[5:3];
        lvl     = selected_level_reg;
        mode    = manual_mode_reg;
        on_ext  = {2'b00, on_interval_reg};
        off_ext = {1'b0, on_interval_reg, 1'b0};

        manual_mode_next    = manual_mode_reg;
        auto_level_next     = auto_level_reg;
        selected_level_next = selected_level_reg;
        phase_minutes_next  = phase_minutes_reg;
        open_phase_next     = open_phase_reg;
        drive_position_next = drive_position_reg;

        case (s_tuser)
            vdic_pkg::ACT_TICK: begin
                if (lvl == 3'd1) begin
                    if (open_phase_reg && phase_minutes_reg >= on_ext) begin
                        open_phase_next     = 1'b0;
                        drive_position_next = '0;
                        phase_minutes_next  = '0;
                    end else if (!open_phase_reg && phase_minutes_reg >= off_ext) begin
                        open_phase_next     = 1'b1;
                        drive_position_next = vdic_pkg::PULSE_POS;
                        phase_minutes_next  = '0;
                    end
                end else if (lvl == 3'd2) begin
                    if (phase_minutes_reg >= on_ext) begin
                        phase_minutes_next  = '0;
                        open_phase_next     = !open_phase_reg;
                        drive_position_next = open_phase_reg ? '0 : vdic_pkg::PULSE_POS;
                    end
                end else begin
                    drive_position_next = lvl;
                    open_phase_next     = (lvl != 3'd0);
                end
                if (phase_minutes_next != vdic_pkg::COUNT_MAX) begin
                    phase_minutes_next = phase_minutes_next + 1'b1;
                end
            end
            vdic_pkg::ACT_SCAN: begin
                if (b_auto) begin
                    mode = vdic_pkg::MODE_AUTO;
                end
                if (b_up) begin
                    mode = (mode >= vdic_pkg::LEVEL_MAX) ? vdic_pkg::LEVEL_MAX : mode + 1'b1;
                end
                if (b_down && mode != 3'd0) begin
                    mode = mode - 1'b1;
                end
                manual_mode_next    = mode;
                selected_level_next = (mode < vdic_pkg::MODE_AUTO) ? mode : auto_level_reg;
            end
            vdic_pkg::ACT_REMOTE: begin
                auto_level_next = (remote > vdic_pkg::LEVEL_MAX) ? vdic_pkg::LEVEL_MAX : remote;
            end
            default: begin
            end
        endcase

        result_next.dac_code       = vdic_pkg::dac_of(drive_position_next);
        result_next.valve_open     = open_phase_next;
        result_next.valve_position = drive_position_next;
        result_next.level_selected = selected_level_next;
        result_next.manual_active  = (manual_mode_next < vdic_pkg::MODE_AUTO);

        if (s_xfer) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_interval_reg    <= vdic_pkg::INTERVAL_RESET;
            manual_mode_reg    <= vdic_pkg::MODE_AUTO;
            auto_level_reg     <= vdic_pkg::LEVEL_MAX;
            selected_level_reg <= vdic_pkg::LEVEL_MAX;
            phase_minutes_reg  <= '0;
            open_phase_reg     <= 1'b1;
            drive_position_reg <= vdic_pkg::LEVEL_MAX;
            m_tvalid_reg       <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                on_interval_reg <= cfg_data;
            end
            if (s_xfer) begin
                manual_mode_reg    <= manual_mode_next;
                auto_level_reg     <= auto_level_next;
                selected_level_reg <= selected_level_next;
                phase_minutes_reg  <= phase_minutes_next;
                open_phase_reg     <= open_phase_next;
                drive_position_reg <= drive_position_next;
            end
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            result_reg <= result_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> m_tvalid_reg)
        else $error("accepted item produced no result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (result_reg.valve_position <= vdic_pkg::LEVEL_MAX &&
                          result_reg.dac_code == vdic_pkg::dac_of(result_reg.valve_position)))
        else $error("result position and converter code disagree");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (selected_level_reg <= vdic_pkg::LEVEL_MAX && auto_level_reg <= vdic_pkg::LEVEL_MAX &&
         manual_mode_reg <= vdic_pkg::MODE_AUTO))
        else $error("level state out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && result_reg.manual_active) |->
            (result_reg.level_selected <= vdic_pkg::LEVEL_MAX))
        else $error("manual result with invalid level");

endmodule

[tb/vdic_tb_pkg.sv]
// Scoreboard for the valve sequencer testbench: predicts each result and checks it.
`timescale 1ns / 1ps

package vdic_tb_pkg;

    import vdic_pkg::*;

    localparam logic [1:0]         ACT_SPARE        = 2'd3;
    localparam logic [LEVEL_W-1:0] CLOSED_POS       = 3'd0;
    localparam logic [LEVEL_W-1:0] SLOW_PULSE_LEVEL = 3'd1;
    localparam logic [LEVEL_W-1:0] FAST_PULSE_LEVEL = 3'd2;
    localparam int unsigned        CODE_PER_STEP    = 819;
    localparam int unsigned        REPORT_LIMIT     = 20;

    class valve_scoreboard;

        logic [INTERVAL_W-1:0] on_minutes;
        logic [LEVEL_W-1:0]    mode;
        logic [LEVEL_W-1:0]    auto_lvl;
        logic [LEVEL_W-1:0]    sel;
        logic [LEVEL_W-1:0]    pos;
        logic [COUNT_W-1:0]    minutes;
        logic                  open_ph;
        result_t               due_q[$];
        int unsigned           mismatches;
        int unsigned           results_seen;
        int unsigned           action_count[4];

        function new();
            on_minutes   = INTERVAL_RESET;
            mode         = MODE_AUTO;
            auto_lvl     = LEVEL_MAX;
            sel          = LEVEL_MAX;
            pos          = LEVEL_MAX;
            minutes      = '0;
            open_ph      = 1'b1;
            mismatches   = 0;
            results_seen = 0;
            foreach (action_count[i]) action_count[i] = 0;
        endfunction

        function void set_interval(logic [INTERVAL_W-1:0] value);
            on_minutes = value;
        endfunction

        function int unsigned pending();
            return due_q.size();
        endfunction

        function void step_minute();
            int cnt;
            int lim;
            cnt = minutes;
            lim = on_minutes;
            if (sel == SLOW_PULSE_LEVEL) begin
                if (open_ph && cnt >= lim) begin
                    open_ph = 1'b0;
                    pos     = CLOSED_POS;
                    cnt     = 0;
                end else if (!open_ph && cnt >= 2 * lim) begin
                    open_ph = 1'b1;
                    pos     = PULSE_POS;
                    cnt     = 0;
                end
            end else if (sel == FAST_PULSE_LEVEL) begin
                if (cnt >= lim) begin
                    cnt     = 0;
                    open_ph = !open_ph;
                    pos     = open_ph ? PULSE_POS : CLOSED_POS;
                end
            end else begin
                pos     = sel;
                open_ph = (sel != CLOSED_POS);
            end
            if (cnt < COUNT_MAX) cnt++;
            minutes = COUNT_W'(cnt);
        endfunction

        function void scan_panel(bit btn_a, bit btn_u, bit btn_d);
            int m;
            m = mode;
            if (btn_a) m = MODE_AUTO;
            if (btn_u) begin
                m++;
                if (m > LEVEL_MAX) m = LEVEL_MAX;
            end
            if (btn_d && m > 0) m--;
            mode = LEVEL_W'(m);
            sel  = (m < MODE_AUTO) ? mode : auto_lvl;
        endfunction

        function void note_item(logic [S_USER_W-1:0] act, logic [S_DATA_W-1:0] data);
            result_t r;
            action_count[act]++;
            case (act)
                ACT_TICK:   step_minute();
                ACT_SCAN:   scan_panel(data[0], data[1], data[2]);
                ACT_REMOTE: auto_lvl = (data[5:3] > LEVEL_MAX) ? LEVEL_MAX : data[5:3];
                default:    ;
            endcase
            r.dac_code       = DAC_W'(int'(pos) * CODE_PER_STEP);
            r.valve_open     = open_ph;
            r.valve_position = pos;
            r.level_selected = sel;
            r.manual_active  = (mode < MODE_AUTO);
            due_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [DAC_W-1:0] want,
                                    logic [DAC_W-1:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: %s mismatch, expected %0d, got %0d",
                             $time, name, want, got);
            end
        endfunction

        function void check_result(logic [M_DATA_W-1:0] data);
            result_t want;
            result_t got;
            got = data[$bits(result_t)-1:0];
            results_seen++;
            if (due_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result %h arrived with nothing expected, expected none",
                             $time, data);
                return;
            end
            want = due_q.pop_front();
            compare_field("dac_code", want.dac_code, got.dac_code);
            compare_field("valve_open", want.valve_open, got.valve_open);
            compare_field("valve_position", want.valve_position, got.valve_position);
            compare_field("level_selected", want.level_selected, got.level_selected);
            compare_field("manual_active", want.manual_active, got.manual_active);
            compare_field("padding", '0, DAC_W'(data[M_DATA_W-1:$bits(result_t)]));
        endfunction

    endclass

endpackage

[tb/tb_valve_duty_interval_controller_core.sv]
// Top-level testbench for the valve sequencer core: stimulus, handshakes and final verdict.
`timescale 1ns / 1ps

module tb_valve_duty_interval_controller_core;

    import vdic_pkg::*;
    import vdic_tb_pkg::*;

    localparam int unsigned SAT_TICKS    = 1030;
    localparam int unsigned REOPEN_TICKS = 280;
    localparam int unsigned PHASE_ITEMS  = 80;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [S_USER_W-1:0]   s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [INTERVAL_W-1:0] cfg_data;

    valve_scoreboard sb;
    bit              tx_calm;
    bit              rx_calm;
    int unsigned     ticks_sent;
    int unsigned     mid_interval;

    valve_duty_interval_controller_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (m_tvalid === 1'b1 && m_tready === 1'b1) sb.check_result(m_tdata);
            if (s_tvalid === 1'b1 && s_tready === 1'b1) sb.note_item(s_tuser, s_tdata);
            if (cfg_valid === 1'b1 && cfg_ready === 1'b1) sb.set_interval(cfg_data);
        end
    end

    // result side: stall a random number of cycles before each transfer, none while calm
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = rx_calm ? 0 : $urandom_range(0, 4);
            repeat (stall) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    end

    function automatic logic [S_DATA_W-1:0] panel_word(bit btn_a, bit btn_u, bit btn_d,
                                                       logic [LEVEL_W-1:0] remote);
        return {2'b00, remote, btn_d, btn_u, btn_a};
    endfunction

    task automatic send_item(input logic [S_USER_W-1:0] act, input logic [S_DATA_W-1:0] data);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 4);
        if ($urandom_range(0, 59) == 0) tx_calm = !tx_calm;
        if ($urandom_range(0, 59) == 0) rx_calm = !rx_calm;
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= data;
        do @(posedge aclk); while (s_tready !== 1'b1);
        if (act == ACT_TICK) ticks_sent++;
    endtask

    task automatic send_tick();
        send_item(ACT_TICK, panel_word($urandom_range(0, 1), $urandom_range(0, 1),
                                       $urandom_range(0, 1), $urandom_range(0, 7)));
    endtask

    // hold the input until every pending result has been transferred
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_interval(input logic [INTERVAL_W-1:0] value);
        drain();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_item();
        int pick;
        logic [S_USER_W-1:0] act;
        pick = $urandom_range(0, 99);
        if (pick < 55)      act = ACT_TICK;
        else if (pick < 80) act = ACT_SCAN;
        else if (pick < 95) act = ACT_REMOTE;
        else                act = ACT_SPARE;
        send_item(act, panel_word($urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0,
                                  $urandom_range(0, 2) == 0, $urandom_range(0, 7)));
    endtask

    initial begin
        int unsigned start_ticks;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= ACT_TICK;
        m_tready   <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_data   <= '0;
        aresetn    <= 1'b0;
        tx_calm    = 1'b0;
        rx_calm    = 1'b0;
        ticks_sent = 0;
        sb         = new();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: spare action, remote clamp, every button path, pulse levels
        send_item(ACT_SPARE, panel_word(1, 1, 1, 3'd7));
        send_tick();
        send_item(ACT_REMOTE, panel_word(0, 0, 0, 3'd7));
        send_item(ACT_REMOTE, panel_word(1, 1, 1, 3'd6));
        send_item(ACT_REMOTE, panel_word(0, 0, 0, 3'd0));
        send_item(ACT_SCAN, panel_word(1, 0, 0, 3'd5));
        send_tick();
        send_item(ACT_SCAN, panel_word(0, 1, 0, 3'd0));
        send_item(ACT_SCAN, panel_word(0, 0, 1, 3'd0));
        send_item(ACT_SCAN, panel_word(1, 1, 1, 3'd0));
        send_item(ACT_SCAN, panel_word(1, 0, 1, 3'd0));
        repeat (3) send_item(ACT_SCAN, panel_word(0, 0, 1, 3'd0));
        repeat (5) send_tick();
        send_item(ACT_SCAN, panel_word(0, 0, 1, 3'd0));
        repeat (4) send_tick();
        send_item(ACT_SCAN, panel_word(0, 0, 1, 3'd0));
        send_item(ACT_SCAN, panel_word(0, 0, 1, 3'd7));
        send_tick();

        write_interval(8'd0);
        repeat (PHASE_ITEMS) random_item();
        write_interval(8'd255);
        repeat (PHASE_ITEMS) random_item();
        write_interval(8'd1);
        repeat (PHASE_ITEMS) random_item();
        mid_interval = $urandom_range(2, 9);
        write_interval(INTERVAL_W'(mid_interval));
        repeat (PHASE_ITEMS) random_item();

        // hold level 5 until the counter saturates, then drop to the slow pulse level
        write_interval(8'd130);
        send_item(ACT_REMOTE, panel_word(0, 0, 0, 3'd5));
        send_item(ACT_SCAN, panel_word(1, 0, 0, 3'd5));
        start_ticks = ticks_sent;
        while (ticks_sent < start_ticks + SAT_TICKS) begin
            if ($urandom_range(0, 99) < 85) send_tick();
            else send_item($urandom_range(0, 1) ? ACT_REMOTE : ACT_SPARE,
                           panel_word($urandom_range(0, 1), $urandom_range(0, 1),
                                      $urandom_range(0, 1), $urandom_range(0, 7)));
        end
        send_item(ACT_REMOTE, panel_word(0, 0, 0, 3'd1));
        send_item(ACT_SCAN, panel_word(1, 0, 0, 3'd1));
        repeat (REOPEN_TICKS) send_tick();

        drain();
        $display("Covered %0d minute ticks, %0d panel scans, %0d remote setpoints,",
                 sb.action_count[ACT_TICK], sb.action_count[ACT_SCAN],
                 sb.action_count[ACT_REMOTE]);
        $display("%0d spare actions; checked %0d results over on-intervals 4, 0, 255, 1,",
                 sb.action_count[ACT_SPARE], sb.results_seen);
        $display("%0d and 130 with counter saturation", mid_interval);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
